FILE: hdl/sbsm_pkg.sv
// Shared types and constants for the serial bank switch mapper.
// No dependencies; used by sbsm_core and serial_bank_switch_mapper.
package sbsm_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned MAP_W    = 22;
  localparam int unsigned MIRROR_W = 2;
  localparam int unsigned COUNT_W  = 8;

  localparam logic [4:0]       CONTROL_RESET = 5'h1c;
  localparam logic [4:0]       PRG_MODE_BITS = 5'h0c;
  localparam logic [2:0]       LOAD_LAST_BIT = 3'd4;
  localparam logic [MAP_W-1:0] WRAM_BASE     = 22'h006000;
  localparam logic [7:0]       PRG_COUNT_RESET = 8'd2;
  localparam logic [7:0]       CHR_COUNT_RESET = 8'd0;

  typedef enum logic [2:0] {
    REQ_PRG_READ  = 3'd0,
    REQ_PRG_WRITE = 3'd1,
    REQ_CHR_READ  = 3'd2,
    REQ_WRAM      = 3'd3,
    REQ_CHR_WRITE = 3'd4
  } req_type_t;

  typedef enum logic [1:0] {
    REG_CONTROL  = 2'd0,
    REG_CHR_LOW  = 2'd1,
    REG_CHR_HIGH = 2'd2,
    REG_PRG      = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A = 2'd0,
    PRG_MODE_32K_B = 2'd1,
    PRG_MODE_FIX_LOW  = 2'd2,
    PRG_MODE_FIX_HIGH = 2'd3
  } prg_mode_t;

  localparam logic CFG_PRG_COUNT = 1'b0;
  localparam logic CFG_CHR_COUNT = 1'b1;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } sbsm_req_t;

  typedef struct packed {
    logic [MIRROR_W-1:0] mirror_mode;
    logic [MAP_W-1:0]    mapped_addr;
  } sbsm_result_t;

endpackage

FILE: hdl/sbsm_core.sv
// Mapper state, serial loader and address translation for one word per cycle.
// Depends on sbsm_pkg.
module sbsm_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  sbsm_pkg::sbsm_req_t                 req,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sbsm_pkg::COUNT_W-1:0]        cfg_data,
  output sbsm_pkg::sbsm_result_t              result
);

  logic [7:0] prg_count;
  logic [7:0] chr_count;
  logic [4:0] shift_value, shift_value_next;
  logic [2:0] bit_count, bit_count_next;
  logic [4:0] control_word, control_word_next;
  logic [4:0] chr_low, chr_low_next;
  logic [4:0] chr_high, chr_high_next;
  logic [4:0] chr_whole, chr_whole_next;
  logic [3:0] prg_low, prg_low_next;
  logic [3:0] prg_high, prg_high_next;
  logic       prg_is_last, prg_is_last_next;
  logic [2:0] prg_whole, prg_whole_next;
  logic [1:0] mirror, mirror_next;

  logic [4:0]                   shifted;
  logic [7:0]                   prg_bank;
  logic [sbsm_pkg::MAP_W-1:0]   mapped;
  sbsm_pkg::reg_sel_t           reg_sel;
  sbsm_pkg::prg_mode_t          prg_mode;
  logic                         chr_4k;
  logic                         is_write;
  logic                         is_ctrl_write;

  assign prg_mode = sbsm_pkg::prg_mode_t'(control_word[3:2]);
  assign chr_4k   = control_word[4];
  assign reg_sel  = sbsm_pkg::reg_sel_t'(req.addr[14:13]);
  assign shifted  = {req.data[0], shift_value[4:1]};
  assign is_write = en && (req.req_type == sbsm_pkg::REQ_PRG_WRITE);
  assign is_ctrl_write = is_write && req.addr[15];

  always_comb begin
    shift_value_next = shift_value;
    bit_count_next   = bit_count;
    control_word_next = control_word;
    chr_low_next     = chr_low;
    chr_high_next    = chr_high;
    chr_whole_next   = chr_whole;
    prg_low_next     = prg_low;
    prg_high_next    = prg_high;
    prg_is_last_next = prg_is_last;
    prg_whole_next   = prg_whole;
    mirror_next      = mirror;
    if (is_ctrl_write) begin
      if (req.data[7]) begin
        shift_value_next  = '0;
        bit_count_next    = '0;
        control_word_next = control_word | sbsm_pkg::PRG_MODE_BITS;
      end else if (bit_count == sbsm_pkg::LOAD_LAST_BIT) begin
        shift_value_next = '0;
        bit_count_next   = '0;
        unique case (reg_sel)
          sbsm_pkg::REG_CONTROL: begin
            control_word_next = shifted;
            mirror_next       = shifted[1:0];
          end
          sbsm_pkg::REG_CHR_LOW: begin
            if (chr_4k) chr_low_next = shifted;
            else        chr_whole_next = shifted;
          end
          sbsm_pkg::REG_CHR_HIGH: begin
            if (chr_4k) chr_high_next = shifted;
          end
          sbsm_pkg::REG_PRG: begin
            unique case (prg_mode)
              sbsm_pkg::PRG_MODE_32K_A,
              sbsm_pkg::PRG_MODE_32K_B: prg_whole_next = shifted[3:1];
              sbsm_pkg::PRG_MODE_FIX_LOW: begin
                prg_high_next    = shifted[3:0];
                prg_is_last_next = 1'b0;
                prg_low_next     = '0;
              end
              sbsm_pkg::PRG_MODE_FIX_HIGH: begin
                prg_is_last_next = 1'b1;
                prg_low_next     = shifted[3:0];
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end else begin
        shift_value_next = shifted;
        bit_count_next   = bit_count + 3'd1;
      end
    end
  end

  always_comb begin
    if (!(req.addr[15] && req.addr[14])) prg_bank = {4'd0, prg_low};
    else if (prg_is_last)                prg_bank = prg_count - 8'd1;
    else                                 prg_bank = {4'd0, prg_high};
  end

  always_comb begin
    unique case (req.req_type)
      sbsm_pkg::REQ_PRG_READ: begin
        if (control_word[3]) mapped = {prg_bank, req.addr[13:0]};
        else                 mapped = {4'd0, prg_whole, req.addr[14:0]};
      end
      sbsm_pkg::REQ_CHR_READ: begin
        if (chr_count == 8'd0) mapped = {6'd0, req.addr};
        else if (chr_4k)
          mapped = {5'd0, ((req.addr[15:12] == 4'd0) ? chr_low : chr_high),
                    req.addr[11:0]};
        else
          mapped = {4'd0, chr_whole, req.addr[12:0]};
      end
      sbsm_pkg::REQ_WRAM:      mapped = {6'd0, req.addr} - sbsm_pkg::WRAM_BASE;
      sbsm_pkg::REQ_CHR_WRITE: mapped = {6'd0, req.addr};
      default:                 mapped = '0;
    endcase
  end

  assign result.mapped_addr = mapped;
  assign result.mirror_mode = mirror_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count    <= sbsm_pkg::PRG_COUNT_RESET;
      chr_count    <= sbsm_pkg::CHR_COUNT_RESET;
      shift_value  <= '0;
      bit_count    <= '0;
      control_word <= sbsm_pkg::CONTROL_RESET;
      chr_low      <= '0;
      chr_high     <= '0;
      chr_whole    <= '0;
      prg_low      <= '0;
      prg_high     <= '0;
      prg_is_last  <= 1'b1;
      prg_whole    <= '0;
      mirror       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sbsm_pkg::CFG_PRG_COUNT: prg_count <= cfg_data;
          sbsm_pkg::CFG_CHR_COUNT: chr_count <= cfg_data;
          default: ;
        endcase
      end
      shift_value  <= shift_value_next;
      bit_count    <= bit_count_next;
      control_word <= control_word_next;
      chr_low      <= chr_low_next;
      chr_high     <= chr_high_next;
      chr_whole    <= chr_whole_next;
      prg_low      <= prg_low_next;
      prg_high     <= prg_high_next;
      prg_is_last  <= prg_is_last_next;
      prg_whole    <= prg_whole_next;
      mirror       <= mirror_next;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= sbsm_pkg::LOAD_LAST_BIT)
    else $error("serial loader count out of range");

  a_reset_write: assert property (@(posedge clk) disable iff (rst)
    is_ctrl_write && req.data[7] |=> control_word[3:2] == 2'b11 && bit_count == 3'd0)
    else $error("loader reset did not force PRG mode");

  a_low_write: assert property (@(posedge clk) disable iff (rst)
    is_write && !req.addr[15] |=> $stable(control_word) && $stable(bit_count)
      && $stable(shift_value))
    else $error("write below register window changed state");

  a_mirror_follows: assert property (@(posedge clk) disable iff (rst)
    is_ctrl_write && !req.data[7] && bit_count == sbsm_pkg::LOAD_LAST_BIT
      && reg_sel == sbsm_pkg::REG_CONTROL |=> mirror == control_word[1:0])
    else $error("mirroring does not follow control load");
`endif

endmodule

FILE: hdl/serial_bank_switch_mapper.sv
// Serial-loader bank-switching cartridge mapper, top level with stream ports.
// Maps one bus access word per clock. A word is taken in every cycle while the
// two-entry output buffer has room; its result is registered into the output
// entry, or into the skid entry while the output entry is held. The bank
// registers update in the same cycle as the access, so back-to-back accesses
// see each other's effects. Depends on sbsm_pkg and sbsm_core.
module serial_bank_switch_mapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // addr[15:0], data[23:16]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // mapped_addr[21:0], mirror_mode[23:22]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  sbsm_pkg::sbsm_req_t    req;
  sbsm_pkg::sbsm_result_t result;
  sbsm_pkg::sbsm_result_t out_q;
  sbsm_pkg::sbsm_result_t skid_q;
  logic                   skid_valid;
  logic                   accept;
  logic                   take;

  assign req.req_type = s_tuser;
  assign req.addr     = s_tdata[15:0];
  assign req.data     = s_tdata[23:16];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = m_tvalid && m_tready;
  assign m_tdata  = out_q;

  sbsm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .en        (accept),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          out_q      <= skid_q;
          skid_valid <= 1'b0;
        end else if (accept) begin
          out_q <= result;
        end else begin
          m_tvalid <= 1'b0;
        end
      end else if (accept) begin
        if (!m_tvalid) begin
          out_q    <= result;
          m_tvalid <= 1'b1;
        end else begin
          skid_q     <= result;
          skid_valid <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry without output entry");

  a_accept_shows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word produced no result");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && take |=> !skid_valid && m_tvalid)
    else $error("skid entry lost on drain");
`endif

endmodule

FILE: tb/sv/serial_bank_switch_mapper_tb.sv
// Self-checking testbench for serial_bank_switch_mapper: predicts every mapped access
// with its own copy of the loader, bank registers and bank counts. Depends on sbsm_pkg.
`timescale 1ns / 1ps

module serial_bank_switch_mapper_tb;

  localparam int         STALL_LIMIT      = 5000;
  localparam int         NUM_SETTINGS     = 6;
  localparam int         ITEMS_PER_HALF   = 125;
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // addr[15:0], data[23:16]
  logic [2:0]  s_tuser = '0;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // mapped_addr[21:0], mirror_mode[23:22]
  logic        cfg_we = 1'b0;
  logic        cfg_index = sbsm_pkg::CFG_PRG_COUNT;
  logic [7:0]  cfg_data = '0;

  serial_bank_switch_mapper u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mapper state as the testbench sees it
  logic [4:0] ld_shift;
  logic [2:0] ld_count;
  logic [4:0] ctrl_reg;
  logic [4:0] chr_lo_bank;
  logic [4:0] chr_hi_bank;
  logic [4:0] chr_8k_bank;
  logic [3:0] prg_lo_bank;
  logic [7:0] prg_hi_bank;
  logic       prg_hi_fixed;
  logic [2:0] prg_32k_bank;
  logic [1:0] mirror_sel;
  logic [7:0] prg_banks_cfg;
  logic [7:0] chr_banks_cfg;

  sbsm_pkg::sbsm_req_t    pending_reqs[$];
  sbsm_pkg::sbsm_result_t expected_maps[$];
  sbsm_pkg::sbsm_req_t    cur_req;
  sbsm_pkg::sbsm_result_t want_map;

  int  send_gap = 0;
  int  sink_stall = 0;
  int  idle_cycles = 0;
  int  n_errors = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_loads = 0;
  int  n_effective = 0;
  int  n_settings = 0;
  bit  no_idle = 1'b0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sbsm_pkg::sbsm_result_t map_access(sbsm_pkg::sbsm_req_t rq);
    sbsm_pkg::sbsm_result_t res;
    logic [7:0]             bank;
    logic [4:0]             loaded;
    res.mapped_addr = '0;
    case (sbsm_pkg::req_type_t'(rq.req_type))
      sbsm_pkg::REQ_PRG_READ: begin
        if (ctrl_reg[3:2] == sbsm_pkg::PRG_MODE_FIX_LOW ||
            ctrl_reg[3:2] == sbsm_pkg::PRG_MODE_FIX_HIGH) begin
          if (rq.addr <= 16'hbfff) bank = {4'b0, prg_lo_bank};
          else if (prg_hi_fixed) bank = prg_banks_cfg - 8'd1;
          else bank = prg_hi_bank;
          res.mapped_addr = {bank, rq.addr[13:0]};
        end else begin
          res.mapped_addr = {4'b0, prg_32k_bank, rq.addr[14:0]};
        end
      end
      sbsm_pkg::REQ_PRG_WRITE: begin
        if (rq.addr[15]) begin
          if (rq.data[7]) begin
            ld_shift = '0;
            ld_count = '0;
            ctrl_reg = ctrl_reg | sbsm_pkg::PRG_MODE_BITS;
          end else begin
            ld_shift = {rq.data[0], ld_shift[4:1]};
            ld_count = ld_count + 3'd1;
            if (ld_count >= 3'd5) begin
              loaded = ld_shift;
              ld_shift = '0;
              ld_count = '0;
              n_loads++;
              case (sbsm_pkg::reg_sel_t'(rq.addr[14:13]))
                sbsm_pkg::REG_CONTROL: begin
                  ctrl_reg = loaded;
                  mirror_sel = loaded[1:0];
                end
                sbsm_pkg::REG_CHR_LOW: begin
                  if (ctrl_reg[4]) chr_lo_bank = loaded;
                  else chr_8k_bank = loaded;
                end
                sbsm_pkg::REG_CHR_HIGH: begin
                  if (ctrl_reg[4]) chr_hi_bank = loaded;
                end
                sbsm_pkg::REG_PRG: begin
                  case (sbsm_pkg::prg_mode_t'(ctrl_reg[3:2]))
                    sbsm_pkg::PRG_MODE_32K_A,
                    sbsm_pkg::PRG_MODE_32K_B: prg_32k_bank = loaded[3:1];
                    sbsm_pkg::PRG_MODE_FIX_LOW: begin
                      prg_hi_bank = {4'b0, loaded[3:0]};
                      prg_hi_fixed = 1'b0;
                      prg_lo_bank = '0;
                    end
                    sbsm_pkg::PRG_MODE_FIX_HIGH: begin
                      prg_hi_fixed = 1'b1;
                      prg_lo_bank = loaded[3:0];
                    end
                  endcase
                end
              endcase
            end
          end
        end
      end
      sbsm_pkg::REQ_CHR_READ: begin
        if (chr_banks_cfg == 8'd0)
          res.mapped_addr = {6'b0, rq.addr};
        else if (ctrl_reg[4])
          res.mapped_addr = {5'b0, (rq.addr <= 16'h0fff) ? chr_lo_bank : chr_hi_bank,
                             rq.addr[11:0]};
        else
          res.mapped_addr = {4'b0, chr_8k_bank, rq.addr[12:0]};
      end
      sbsm_pkg::REQ_WRAM:      res.mapped_addr = {6'b0, rq.addr} - sbsm_pkg::WRAM_BASE;
      sbsm_pkg::REQ_CHR_WRITE: res.mapped_addr = {6'b0, rq.addr};
      default:                 res.mapped_addr = '0;
    endcase
    res.mirror_mode = mirror_sel;
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [21:0] want, logic [21:0] got);
    n_errors++;
    if (n_errors <= 10)
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_maps.push_back(map_access(cur_req));
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_req.data, cur_req.addr};
          s_tuser <= cur_req.req_type;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_maps.size() == 0) begin
          note_mismatch("unexpected word", '0, m_tdata[21:0]);
        end else begin
          want_map = expected_maps.pop_front();
          if (m_tdata[21:0] !== want_map.mapped_addr)
            note_mismatch("mapped_addr", want_map.mapped_addr, m_tdata[21:0]);
          if (m_tdata[23:22] !== want_map.mirror_mode)
            note_mismatch("mirror_mode", 22'(want_map.mirror_mode), 22'(m_tdata[23:22]));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic queue_req(logic [2:0] rtype, logic [15:0] addr, logic [7:0] data);
    sbsm_pkg::sbsm_req_t rq;
    rq.req_type = rtype;
    rq.addr = addr;
    rq.data = data;
    pending_reqs.push_back(rq);
    if (rtype <= sbsm_pkg::REQ_CHR_WRITE &&
        !(rtype == sbsm_pkg::REQ_PRG_WRITE && !addr[15]))
      n_effective++;
  endtask

  task automatic queue_random_access();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      queue_req(sbsm_pkg::REQ_PRG_READ, 16'($urandom), 8'($urandom));
    else if (r < 65)
      queue_req(sbsm_pkg::REQ_CHR_READ,
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom) & 16'h1fff,
                8'($urandom));
    else if (r < 78)
      queue_req(sbsm_pkg::REQ_WRAM, 16'($urandom), 8'($urandom));
    else if (r < 88)
      queue_req(sbsm_pkg::REQ_CHR_WRITE, 16'($urandom), 8'($urandom));
    else if (r < 95)
      queue_req(sbsm_pkg::REQ_PRG_WRITE, {1'b0, 15'($urandom)}, 8'($urandom));
    else
      queue_req(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)), 16'($urandom),
                8'($urandom));
  endtask

  task automatic queue_serial_load(sbsm_pkg::reg_sel_t sel, logic [4:0] value, bit mixed);
    for (int i = 0; i < 5; i++) begin
      queue_req(sbsm_pkg::REQ_PRG_WRITE, {1'b1, sel, 13'($urandom)},
                {1'b0, 6'($urandom), value[i]});
      if (mixed && $urandom_range(0, 3) == 0) queue_random_access();
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_maps.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_bank_counts(logic [7:0] prg_count, logic [7:0] chr_count);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sbsm_pkg::CFG_PRG_COUNT;
    cfg_data <= prg_count;
    @(posedge clk);
    cfg_index <= sbsm_pkg::CFG_CHR_COUNT;
    cfg_data <= chr_count;
    @(posedge clk);
    cfg_we <= 1'b0;
    prg_banks_cfg = prg_count;
    chr_banks_cfg = chr_count;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin
    int         r;
    int         target;
    logic [7:0] prg_count;
    logic [7:0] chr_count;

    ld_shift = '0;
    ld_count = '0;
    ctrl_reg = sbsm_pkg::CONTROL_RESET;
    chr_lo_bank = '0;
    chr_hi_bank = '0;
    chr_8k_bank = '0;
    prg_lo_bank = '0;
    prg_hi_bank = '0;
    prg_hi_fixed = 1'b1;
    prg_32k_bank = '0;
    mirror_sel = '0;
    prg_banks_cfg = sbsm_pkg::PRG_COUNT_RESET;
    chr_banks_cfg = sbsm_pkg::CHR_COUNT_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_req(sbsm_pkg::REQ_PRG_READ, 16'h8000, 8'h00);
    queue_req(sbsm_pkg::REQ_PRG_READ, 16'hffff, 8'hff);
    queue_req(sbsm_pkg::REQ_PRG_READ, 16'h0000, 8'h00);
    queue_req(sbsm_pkg::REQ_CHR_READ, 16'h1fff, 8'h55);
    queue_req(sbsm_pkg::REQ_WRAM, 16'h6000, 8'haa);
    queue_req(sbsm_pkg::REQ_WRAM, 16'h0000, 8'h00);
    queue_req(sbsm_pkg::REQ_CHR_WRITE, 16'hffff, 8'hff);
    for (int t = REQ_UNUSED_FIRST; t <= REQ_UNUSED_LAST; t++)
      queue_req(3'(t), 16'hffff, 8'hff);
    queue_req(sbsm_pkg::REQ_PRG_WRITE, 16'h7fff, 8'h01);
    queue_req(sbsm_pkg::REQ_PRG_WRITE, 16'h8000, 8'h01);
    queue_req(sbsm_pkg::REQ_PRG_WRITE, 16'h8000, 8'h01);
    queue_req(sbsm_pkg::REQ_PRG_WRITE, 16'hffff, 8'h80);
    queue_serial_load(sbsm_pkg::REG_CONTROL, 5'h0a, 1'b0);
    queue_serial_load(sbsm_pkg::REG_PRG, 5'h1f, 1'b0);
    queue_req(sbsm_pkg::REQ_PRG_READ, 16'hc000, 8'h00);
    queue_req(sbsm_pkg::REQ_PRG_READ, 16'hbfff, 8'h00);
    queue_req(sbsm_pkg::REQ_PRG_WRITE, 16'he000, 8'hff);
    queue_req(sbsm_pkg::REQ_PRG_READ, 16'hffff, 8'h00);
    wait_idle();

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      case (ph)
        0:       {prg_count, chr_count} = {8'd1, 8'd0};
        1:       {prg_count, chr_count} = {8'd255, 8'd255};
        2:       {prg_count, chr_count} = {8'd0, 8'd1};
        3:       {prg_count, chr_count} = {8'd16, 8'd32};
        default: {prg_count, chr_count} = 16'($urandom);
      endcase
      write_bank_counts(prg_count, chr_count);
      for (int half = 0; half < 2; half++) begin
        no_idle = ($urandom_range(0, 4) == 0);
        target = n_effective + ITEMS_PER_HALF;
        while (n_effective < target) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            queue_serial_load(sbsm_pkg::reg_sel_t'($urandom_range(0, 3)), 5'($urandom),
                              1'b1);
            repeat ($urandom_range(1, 4)) queue_random_access();
          end else if (r < 60) begin
            queue_req(sbsm_pkg::REQ_PRG_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
          end else if (r < 70) begin
            repeat ($urandom_range(1, 4))
              queue_req(sbsm_pkg::REQ_PRG_WRITE, {1'b1, 15'($urandom)},
                        {1'b0, 7'($urandom)});
            queue_req(sbsm_pkg::REQ_PRG_WRITE, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
          end else begin
            queue_random_access();
          end
        end
        // hold the sender until every result is back
        wait_idle();
      end
    end

    repeat (5) @(posedge clk);
    $display("Mapped %0d accesses with %0d bank register loads under %0d bank-count settings;",
             n_accepted, n_loads, n_settings);
    $display("%0d result words checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hdl/sbsm_pkg.sv
hdl/sbsm_core.sv
hdl/serial_bank_switch_mapper.sv
tb/sv/serial_bank_switch_mapper_tb.sv
